[src/aes128_block_cipher_core_defines.svh]
// ----------------------------------------------------------------------------
// AES-128 core assertion macros
// Assertion wrappers; define NO_ASSERTIONS to compile them out.
// ----------------------------------------------------------------------------
`ifndef AES128_BLOCK_CIPHER_CORE_DEFINES_SVH
`define AES128_BLOCK_CIPHER_CORE_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define AES_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error("assertion failed");
`define AES_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error("assertion failed");
`else
`define AES_ASSERT_IMP(lbl, ante, cons)
`define AES_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

[src/aes_pkg.sv]
// ----------------------------------------------------------------------------
// AES-128 package
// Byte tables, GF(2^8) helpers, round functions, register indexes.
// ----------------------------------------------------------------------------
package aes_pkg;

	localparam int NumRounds = 10;
	localparam int RkAddrW = 4;

	typedef logic [127:0] blk_t;
	typedef logic [7:0] byte_t;

	typedef enum logic [0:0] {
		REG_KEY_HIGH = 1'b0,
		REG_KEY_LOW  = 1'b1
	} reg_idx_t;

	localparam logic OP_ENCRYPT = 1'b0;

	// status from key expander to core
	typedef struct packed {
		logic busy;
		logic done;
	} kx_status_t;

	function automatic byte_t sbox(input byte_t x);
		byte_t t [256] = '{
		8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
		8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
		8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
		8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
		8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
		8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
		8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
		8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
		8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
		8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
		8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
		8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
		8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
		8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
		8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
		8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
		return t[x];
	endfunction

	function automatic byte_t inv_sbox(input byte_t x);
		byte_t t [256] = '{
		8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
		8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
		8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
		8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
		8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
		8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
		8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
		8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
		8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
		8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
		8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
		8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
		8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
		8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
		8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
		8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d};
		return t[x];
	endfunction

	function automatic byte_t xt(input byte_t x);
		return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
	endfunction

	// byte k of the block sits at bits 127-8k
	function automatic byte_t bget(input blk_t b, input int k);
		return b[127-8*k -: 8];
	endfunction

	function automatic blk_t sub_shift(input blk_t s, input logic inv);
		blk_t o;
		o = '0;
		for (int c = 0; c < 4; c++) begin
			for (int r = 0; r < 4; r++) begin
				if (inv)
					o[127-8*(c*4+r) -: 8] = inv_sbox(bget(s, ((c+4-r)%4)*4+r));
				else
					o[127-8*(c*4+r) -: 8] = sbox(bget(s, ((c+r)%4)*4+r));
			end
		end
		return o;
	endfunction

	function automatic blk_t mix(input blk_t s, input logic inv);
		blk_t o;
		byte_t a0, a1, a2, a3, x4, x8;
		o = '0;
		for (int c = 0; c < 4; c++) begin
			for (int r = 0; r < 4; r++) begin
				a0 = bget(s, c*4+r);
				a1 = bget(s, c*4+(r+1)%4);
				a2 = bget(s, c*4+(r+2)%4);
				a3 = bget(s, c*4+(r+3)%4);
				if (inv) begin
					// 0e.a0 ^ 0b.a1 ^ 0d.a2 ^ 09.a3
					x4 = xt(xt(a0 ^ a2));
					x8 = xt(xt(xt(a0 ^ a1 ^ a2 ^ a3)));
					o[127-8*(c*4+r) -: 8] = x8 ^ x4 ^ xt(a0 ^ a1) ^ a1 ^ a2 ^ a3;
				end else begin
					o[127-8*(c*4+r) -: 8] = xt(a0) ^ xt(a1) ^ a1 ^ a2 ^ a3;
				end
			end
		end
		return o;
	endfunction

endpackage

[src/aes_stream_if.sv]
// ----------------------------------------------------------------------------
// AES stream channel
// Valid/ready channels: one carries an op and a block in, one carries the result.
// ----------------------------------------------------------------------------
interface aes_in_if;
	logic valid;
	logic ready;
	logic op;
	logic [63:0] block_high;
	logic [63:0] block_low;
	modport source (output valid, op, block_high, block_low, input ready);
	modport sink (input valid, op, block_high, block_low, output ready);
endinterface

interface aes_out_if;
	logic valid;
	logic ready;
	logic [63:0] result_high;
	logic [63:0] result_low;
	modport source (output valid, result_high, result_low, input ready);
	modport sink (input valid, result_high, result_low, output ready);
endinterface

[src/aes_key_expand.sv]
// ----------------------------------------------------------------------------
// AES-128 key expander
// One round key per cycle into the 11-entry round-key store.
// ----------------------------------------------------------------------------
module aes_key_expand (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  aes_pkg::blk_t                 key,
	input  logic [aes_pkg::RkAddrW-1:0]   rd_addr,
	output aes_pkg::blk_t                 rd_data,
	output aes_pkg::kx_status_t           status
);
	aes_pkg::blk_t rk_q;
	aes_pkg::byte_t rc_q;
	logic [aes_pkg::RkAddrW-1:0] idx_q;
	logic busy_q;
	logic done_q;
	aes_pkg::blk_t nxt;
	aes_pkg::blk_t mem [aes_pkg::NumRounds+1];
	logic [31:0] t, w0, w1, w2, w3;

	// next round key from the current one
	always_comb begin
		t = {aes_pkg::sbox(rk_q[23:16]) ^ rc_q, aes_pkg::sbox(rk_q[15:8]),
			aes_pkg::sbox(rk_q[7:0]), aes_pkg::sbox(rk_q[31:24])};
		w0 = rk_q[127:96] ^ t;
		w1 = rk_q[95:64] ^ w0;
		w2 = rk_q[63:32] ^ w1;
		w3 = rk_q[31:0] ^ w2;
		nxt = {w0, w1, w2, w3};
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			idx_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			idx_q <= '0;
		end else if (busy_q) begin
			idx_q <= idx_q + 1'b1;
			if (idx_q == aes_pkg::RkAddrW'(aes_pkg::NumRounds)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	// working key and round constant
	always_ff @(posedge clk) begin
		if (start) begin
			rk_q <= key;
			rc_q <= 8'h01;
		end else if (busy_q) begin
			rk_q <= nxt;
			rc_q <= aes_pkg::xt(rc_q);
		end
	end

	// round-key store
	always_ff @(posedge clk) begin
		if (busy_q) mem[idx_q] <= rk_q;
	end

	always_comb rd_data = mem[rd_addr];

	assign status = '{busy: busy_q, done: done_q};
endmodule

[src/aes128_block_cipher_core.sv]
// ----------------------------------------------------------------------------
// AES-128 block cipher core
// ECB encrypt/decrypt, one round per cycle through a shared round unit.
// ----------------------------------------------------------------------------
// channel  dir  fields
// in       in   op, block_high, block_low
// out      out  result_high, result_low
// cfg      in   cfg_we, cfg_idx, cfg_data (key_high, key_low)
// An item is loaded while idle, runs the initial key addition and the ten
// rounds, then waits as a result. After a key write it waits for key expansion.
// Reset clears the key and marks round keys stale. A held result
// stalls the round unit; input is not taken until the result goes.
`include "aes128_block_cipher_core_defines.svh"
module aes128_block_cipher_core (
	input  logic        clk,
	input  logic        arst_n,
	aes_in_if.sink      in,
	aes_out_if.source   out,
	input  logic        cfg_we,
	input  logic        cfg_idx,
	input  logic [63:0] cfg_data
);
	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_KEY  = 5'b00010,
		ST_KEYW = 5'b00100,
		ST_RUN  = 5'b01000,
		ST_OUT  = 5'b10000
	} state_t;

	state_t state_q;
	logic [63:0] key_hi_q, key_lo_q;
	logic kexp_q;
	logic op_q;
	aes_pkg::blk_t st_q;
	logic [aes_pkg::RkAddrW-1:0] rnd_q;
	logic [aes_pkg::RkAddrW-1:0] rk_addr;
	aes_pkg::blk_t rk;
	aes_pkg::kx_status_t kx;
	aes_pkg::blk_t ss, rnd_out;
	logic kx_start;
	logic first, last;

	// key registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_hi_q <= '0;
			key_lo_q <= '0;
		end else if (cfg_we) begin
			if (cfg_idx == aes_pkg::REG_KEY_HIGH) key_hi_q <= cfg_data;
			else key_lo_q <= cfg_data;
		end
	end

	assign kx_start = (state_q == ST_KEY);

	aes_key_expand u_kx (
		.clk(clk), .arst_n(arst_n), .start(kx_start),
		.key({key_hi_q, key_lo_q}), .rd_addr(rk_addr), .rd_data(rk), .status(kx)
	);

	// round index to key address; decrypt walks keys downward
	assign rk_addr = (op_q == aes_pkg::OP_ENCRYPT) ? rnd_q
		: aes_pkg::RkAddrW'(aes_pkg::NumRounds) - rnd_q;
	assign first = (rnd_q == '0);
	assign last = (rnd_q == aes_pkg::RkAddrW'(aes_pkg::NumRounds));

	// shared round unit
	always_comb begin
		ss = aes_pkg::sub_shift(st_q, op_q);
		if (first) rnd_out = st_q ^ rk;
		else if (op_q == aes_pkg::OP_ENCRYPT)
			rnd_out = last ? (ss ^ rk) : (aes_pkg::mix(ss, 1'b0) ^ rk);
		else
			rnd_out = last ? (ss ^ rk) : aes_pkg::mix(ss ^ rk, 1'b1);
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			kexp_q <= 1'b0;
			rnd_q <= '0;
		end else begin
			if (cfg_we) kexp_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					rnd_q <= '0;
					if (in.valid) state_q <= kexp_q ? ST_RUN : ST_KEY;
				end
				ST_KEY: state_q <= ST_KEYW;
				ST_KEYW: begin
					if (kx.done) begin
						kexp_q <= 1'b1;
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					rnd_q <= rnd_q + 1'b1;
					if (last) state_q <= ST_OUT;
				end
				ST_OUT: if (out.ready) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// block state
	always_ff @(posedge clk) begin
		if (in.valid && in.ready) begin
			op_q <= in.op;
			st_q <= {in.block_high, in.block_low};
		end else if (state_q == ST_RUN) begin
			st_q <= rnd_out;
		end
	end

	assign in.ready = (state_q == ST_IDLE);
	assign out.valid = (state_q == ST_OUT);
	assign out.result_high = st_q[127:64];
	assign out.result_low = st_q[63:0];

	`AES_ASSERT_IMP(a_ready_idle, in.ready, !out.valid)
	`AES_ASSERT_NXT(a_run_after_key, state_q == ST_KEYW && kx.done, state_q == ST_RUN)
	`AES_ASSERT_IMP(a_kx_quiet, state_q == ST_RUN, !kx.busy)
	`AES_ASSERT_NXT(a_out_hold, out.valid && !out.ready, out.valid && $stable(st_q))
endmodule
